// ===== hw/rtl/spieps_pkg.sv =====
// Shared types, codes and helper functions of the SPI EEPROM page-split sequencer.
// No dependencies; every other file of the block imports this package.

package spieps_pkg;

	// Geometry of the device and of the request
	localparam int PAGE_BYTES        = 32;
	localparam int PAGE_BITS         = $clog2(PAGE_BYTES);
	localparam int MAX_REQUEST_BYTES = 256;
	localparam int MAX_SEGMENTS      = 9;
	localparam int QUEUE_DEPTH       = 2;

	// Field widths
	localparam int ADDR_W  = 24;
	localparam int COUNT_W = 9;
	localparam int ABITS_W = 5;

	// Address width limits and reset value
	localparam logic [ABITS_W-1:0] ABITS_MIN   = 5'd8;
	localparam logic [ABITS_W-1:0] ABITS_MAX   = 5'd24;
	localparam logic [ABITS_W-1:0] ABITS_RESET = 5'd16;

	// Request opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ERASE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Instruction bytes
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] A8_IN_CMD = 8'h80;

	// Request classes handed from front to back
	localparam logic [1:0] KIND_ERROR = 2'd0;
	localparam logic [1:0] KIND_BUSY  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_SPLIT = 2'd3;

	// Classified request
	typedef struct packed {
		logic [1:0]         kind;
		logic               fill;
		logic [ADDR_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} desc_t;

	// One result item
	typedef struct packed {
		logic [1:0]         status;
		logic               send_write_enable;
		logic [7:0]         command_byte;
		logic [ADDR_W-1:0]  address_field;
		logic [2:0]         header_length;
		logic [COUNT_W-1:0] segment_length;
		logic               fill_erased;
		logic               last;
	} result_t;

	// Command header of one transfer
	typedef struct packed {
		logic [7:0]        cmd;
		logic [ADDR_W-1:0] field;
		logic [2:0]        hlen;
	} header_t;

	// Clamp the configured address width to the supported range
	function automatic logic [ABITS_W-1:0] eff_bits(input logic [ABITS_W-1:0] bits);
		logic [ABITS_W-1:0] r;
		if (bits < ABITS_MIN) begin
			r = ABITS_MIN;
		end else if (bits > ABITS_MAX) begin
			r = ABITS_MAX;
		end else begin
			r = bits;
		end
		return r;
	endfunction

	// Build the command header for an address at a given address width
	function automatic header_t build_header(input logic [7:0] base_cmd,
			input logic [ADDR_W-1:0] addr, input logic [ABITS_W-1:0] bits);
		header_t h;
		h.cmd = base_cmd;
		if (bits <= 5'd9) begin
			h.field = {16'd0, addr[7:0]};
			h.hlen  = 3'd2;
			if (bits == 5'd9 && addr[8]) begin
				h.cmd = base_cmd | A8_IN_CMD;
			end
		end else if (bits <= 5'd16) begin
			h.field = {8'd0, addr[15:0]};
			h.hlen  = 3'd3;
		end else begin
			h.field = addr;
			h.hlen  = 3'd4;
		end
		return h;
	endfunction

endpackage

// ===== hw/rtl/spieps_front.sv =====
// Front end of the sequencer: checks each request and classifies it.
// Depends on spieps_pkg.

module spieps_front (
	input  logic [1:0]                           opcode,
	input  logic [spieps_pkg::ADDR_W-1:0]        start_address,
	input  logic [spieps_pkg::COUNT_W-1:0]       byte_count,
	input  logic                                 device_busy,
	input  logic [spieps_pkg::ABITS_W-1:0]       bits,
	output spieps_pkg::desc_t                    desc
);
	import spieps_pkg::*;

	localparam int END_W = ADDR_W + 1;
	localparam int PG_W  = END_W - PAGE_BITS;

	logic [END_W-1:0] end_addr;
	logic [PG_W-1:0]  page_span;
	logic             count_err;
	logic             range_err;
	logic             span_err;
	logic             bad_op;

	// Last byte address of the request, one bit wider to catch overflow
	assign end_addr = {1'b0, start_address} + END_W'(byte_count) - END_W'(1);

	// Check count, opcode, device range and page span
	assign bad_op    = (opcode != OP_WRITE) && (opcode != OP_ERASE) && (opcode != OP_READ);
	assign count_err = (byte_count == '0) || (byte_count > COUNT_W'(MAX_REQUEST_BYTES));
	assign range_err = (end_addr >> bits) != '0;
	assign page_span = end_addr[END_W-1:PAGE_BITS] - PG_W'(start_address[ADDR_W-1:PAGE_BITS]);
	assign span_err  = (opcode != OP_READ) && (page_span > PG_W'(MAX_SEGMENTS - 1));

	// Classify: errors win over busy
	always_comb begin
		desc.start = start_address;
		desc.count = byte_count;
		desc.fill  = (opcode == OP_ERASE);
		if (bad_op || count_err || range_err || span_err) begin
			desc.kind = KIND_ERROR;
		end else if (device_busy) begin
			desc.kind = KIND_BUSY;
		end else if (opcode == OP_READ) begin
			desc.kind = KIND_READ;
		end else begin
			desc.kind = KIND_SPLIT;
		end
	end

endmodule

// ===== hw/rtl/spieps_queue.sv =====
// Short request queue between front and back end.
// Depends on spieps_pkg.

module spieps_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spieps_pkg::desc_t push_desc,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output spieps_pkg::desc_t head
);
	import spieps_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slots_q[rd_ptr_q];

	// Store an item
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/spieps_back.sv =====
// Back end of the sequencer: splits writes and erases at page boundaries and
// drives the registered result stage. Depends on spieps_pkg.

module spieps_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [spieps_pkg::ABITS_W-1:0] bits,
	input  logic                           q_not_empty,
	input  spieps_pkg::desc_t              q_head,
	output logic                           q_pop,
	output logic                           res_valid,
	input  logic                           res_ready,
	output spieps_pkg::result_t            res
);
	import spieps_pkg::*;

	localparam logic [COUNT_W-1:0] PAGE_LEN = COUNT_W'(PAGE_BYTES);

	logic [ADDR_W-1:0]  seg_addr_q;
	logic [COUNT_W-1:0] remain_q;
	logic               fill_q;
	logic               active_q;
	logic               res_valid_q;
	result_t            res_q;

	logic               out_free;
	logic [COUNT_W-1:0] room;
	logic [COUNT_W-1:0] seg_len;
	logic [COUNT_W-1:0] remain_next;
	header_t            seg_hdr;
	header_t            rd_hdr;
	logic               emit_seg;
	logic               emit_one;
	result_t            one_res;
	result_t            seg_res;

	assign out_free = !res_valid_q || res_ready;

	// Take the next request once the current split is done
	assign q_pop    = q_not_empty && !active_q && (q_head.kind == KIND_SPLIT || out_free);
	assign emit_one = q_pop && (q_head.kind != KIND_SPLIT);
	assign emit_seg = active_q && out_free;

	// Size the current segment up to the page boundary
	assign room        = PAGE_LEN - COUNT_W'(seg_addr_q[PAGE_BITS-1:0]);
	assign seg_len     = (remain_q <= room) ? remain_q : room;
	assign remain_next = remain_q - seg_len;
	assign seg_hdr     = build_header(CMD_WRITE, seg_addr_q, bits);
	assign rd_hdr      = build_header(CMD_READ, q_head.start, bits);

	always_comb begin
		seg_res.status            = ST_OK;
		seg_res.send_write_enable = 1'b1;
		seg_res.command_byte      = seg_hdr.cmd;
		seg_res.address_field     = seg_hdr.field;
		seg_res.header_length     = seg_hdr.hlen;
		seg_res.segment_length    = seg_len;
		seg_res.fill_erased       = fill_q;
		seg_res.last              = (remain_next == '0);
	end

	// Single-result requests: error, busy or read
	always_comb begin
		one_res      = '0;
		one_res.last = 1'b1;
		case (q_head.kind)
			KIND_BUSY: begin
				one_res.status = ST_BUSY;
			end
			KIND_READ: begin
				one_res.status         = ST_OK;
				one_res.command_byte   = rd_hdr.cmd;
				one_res.address_field  = rd_hdr.field;
				one_res.header_length  = rd_hdr.hlen;
				one_res.segment_length = q_head.count;
			end
			default: begin
				one_res.status = ST_ERROR;
			end
		endcase
	end

	// Hold split progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			seg_addr_q <= '0;
			remain_q   <= '0;
			fill_q     <= 1'b0;
		end else if (q_pop && q_head.kind == KIND_SPLIT) begin
			active_q   <= 1'b1;
			seg_addr_q <= q_head.start;
			remain_q   <= q_head.count;
			fill_q     <= q_head.fill;
		end else if (emit_seg) begin
			seg_addr_q <= seg_addr_q + ADDR_W'(seg_len);
			remain_q   <= remain_next;
			if (remain_next == '0) begin
				active_q <= 1'b0;
			end
		end
	end

	// Result register: load a new item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_seg || emit_one) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_seg) begin
			res_q <= seg_res;
		end else if (emit_one) begin
			res_q <= one_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/spi_eeprom_page_split_sequencer_top.sv =====
// Top level of the SPI EEPROM page-split sequencer: configuration register,
// front end, request queue and back end. Depends on spieps_pkg.

// A request (write, erase or read) is checked in the front end in the cycle it
// is accepted and placed in a two-entry queue, so requests are taken one per
// cycle while the queue has room. The back end handles one request at a time:
// an error, busy or read request gives one result, loaded into the output
// register when it is taken from the head of the queue; a write or erase
// spanning n pages (at most nine) first loads the page-split counter, which
// then gives n results, one segment per cycle while the consumer is ready.
// Results leave through a single registered output stage that loads a new item
// in the same cycle the previous one is taken; while the consumer stalls, the
// back end waits. The address width register is written with cfg_we and
// cfg_data while the block is idle; the user must keep to this, since the block
// itself does not enforce it. Values below 8 act as 8 and above 24 act as 24.

module spi_eeprom_page_split_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spieps_pkg::ABITS_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic [spieps_pkg::ADDR_W-1:0]   start_address,
	input  logic [spieps_pkg::COUNT_W-1:0]  byte_count,
	input  logic                            device_busy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic                            send_write_enable,
	output logic [7:0]                      command_byte,
	output logic [spieps_pkg::ADDR_W-1:0]   address_field,
	output logic [2:0]                      header_length,
	output logic [spieps_pkg::COUNT_W-1:0]  segment_length,
	output logic                            fill_erased,
	output logic                            last
);
	import spieps_pkg::*;

	logic [ABITS_W-1:0] address_bits_q;
	logic [ABITS_W-1:0] bits;
	desc_t              in_desc;
	desc_t              head;
	logic               q_full;
	logic               q_not_empty;
	logic               q_pop;
	result_t            res;

	// Hold the address width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_bits_q <= ABITS_RESET;
		end else if (cfg_we) begin
			address_bits_q <= cfg_data;
		end
	end

	assign bits     = eff_bits(address_bits_q);
	assign in_ready = !q_full;

	spieps_front u_front (
		.opcode        (opcode),
		.start_address (start_address),
		.byte_count    (byte_count),
		.device_busy   (device_busy),
		.bits          (bits),
		.desc          (in_desc)
	);

	spieps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_desc (in_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	spieps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bits        (bits),
		.q_not_empty (q_not_empty),
		.q_head      (head),
		.q_pop       (q_pop),
		.res_valid   (out_valid),
		.res_ready   (out_ready),
		.res         (res)
	);

	// Break the result into its ports
	assign status            = res.status;
	assign send_write_enable = res.send_write_enable;
	assign command_byte      = res.command_byte;
	assign address_field     = res.address_field;
	assign header_length     = res.header_length;
	assign segment_length    = res.segment_length;
	assign fill_erased       = res.fill_erased;
	assign last              = res.last;

endmodule
